>>> hw/rtl/cci_pkg.sv
// Shared types, constants and helpers of the class count integral image core.
`timescale 1ns / 1ps
`default_nettype none

package cci_pkg;

  // Grid and table geometry.
  localparam int GridMax    = 32;
  localparam int TableDim   = GridMax + 1;
  localparam int TableDepth = TableDim * TableDim;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CoordW     = 6;
  localparam int CntW       = 11;
  localparam int NumClass   = 4;
  localparam int ClassW     = 2;
  localparam int StepW      = 3;

  localparam logic [CoordW-1:0] GridSizeReset = CoordW'(20);
  localparam logic [CoordW-1:0] GridSizeMin   = CoordW'(2);
  localparam logic [CoordW-1:0] GridSizeMax   = CoordW'(GridMax);

  // Command codes of an input transaction.
  typedef enum logic [1:0] {
    OpLoad   = 2'd0,
    OpRect   = 2'd1,
    OpRegion = 2'd2,
    OpNone   = 2'd3
  } op_e;

  // Region codes of a square-region query.
  localparam logic [3:0] RegTop     = 4'd0;
  localparam logic [3:0] RegBottom  = 4'd1;
  localparam logic [3:0] RegLeft    = 4'd2;
  localparam logic [3:0] RegRight   = 4'd3;
  localparam logic [3:0] RegMinusBr = 4'd4;
  localparam logic [3:0] RegMinusBl = 4'd5;
  localparam logic [3:0] RegMinusTr = 4'd6;
  localparam logic [3:0] RegMinusTl = 4'd7;

  // Step numbers that bound a corner sequence.
  localparam logic [StepW-1:0] StepFirstQuery = StepW'(0);
  localparam logic [StepW-1:0] StepFirstLoad  = StepW'(1);
  localparam logic [StepW-1:0] StepLastSingle = StepW'(3);
  localparam logic [StepW-1:0] StepLastDouble = StepW'(7);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StDrain,
    StWrite,
    StFinish
  } ctrl_state_e;

  // One table entry: one count per class.
  typedef logic [NumClass-1:0][CntW-1:0] entry_t;

  // Half-open rectangle: rows r0..r1-1, columns c0..c1-1.
  typedef struct packed {
    logic [CoordW-1:0] r0;
    logic [CoordW-1:0] c0;
    logic [CoordW-1:0] r1;
    logic [CoordW-1:0] c1;
  } rect_t;

  // Controller to datapath.
  typedef struct packed {
    logic             accept;
    logic             clr_wr;
    logic             rd_en;
    logic [StepW-1:0] step;
    logic             wr_en;
    logic             out_load;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  in_op;
    logic in_bad;
    logic use_b;
    logic is_load;
    logic clear_last;
    logic out_free;
  } ctl_status_t;

  function automatic logic [AddrW-1:0] table_addr(input logic [CoordW-1:0] row,
                                                  input logic [CoordW-1:0] col);
    logic [AddrW-1:0] base;
    base = AddrW'(AddrW'(row) * AddrW'(TableDim));
    return AddrW'(base + AddrW'(col));
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cci_ctrl.sv
// Controller state machine of the class count integral image core.
`timescale 1ns / 1ps
`default_nettype none

module cci_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  cci_pkg::ctl_status_t status_i,
  output cci_pkg::ctl_cmd_t    cmd_o
);

  cci_pkg::ctrl_state_e state_q, state_d;
  logic [cci_pkg::StepW-1:0] step_q, step_d;
  logic [cci_pkg::StepW-1:0] last_step;
  logic accept;

  assign accept    = in_valid_i && (state_q == cci_pkg::StIdle);
  assign last_step = status_i.use_b ? cci_pkg::StepLastDouble : cci_pkg::StepLastSingle;

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      cci_pkg::StClear: begin
        if (status_i.clear_last) state_d = cci_pkg::StIdle;
      end
      cci_pkg::StIdle: begin
        if (accept) begin
          if (status_i.in_op == cci_pkg::OpLoad) begin
            state_d = cci_pkg::StRead;
            step_d  = cci_pkg::StepFirstLoad;
          end else if (status_i.in_op == cci_pkg::OpNone) begin
            state_d = cci_pkg::StIdle;
          end else if (status_i.in_bad) begin
            state_d = cci_pkg::StFinish;
          end else begin
            state_d = cci_pkg::StRead;
            step_d  = cci_pkg::StepFirstQuery;
          end
        end
      end
      cci_pkg::StRead: begin
        if (step_q == last_step) state_d = cci_pkg::StDrain;
        else step_d = step_q + 1'b1;
      end
      cci_pkg::StDrain: begin
        state_d = status_i.is_load ? cci_pkg::StWrite : cci_pkg::StFinish;
      end
      cci_pkg::StWrite: begin
        state_d = cci_pkg::StIdle;
      end
      cci_pkg::StFinish: begin
        if (status_i.out_free) state_d = cci_pkg::StIdle;
      end
      default: begin
        state_d = cci_pkg::StIdle;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.step     = step_q;
    in_stall_o     = 1'b1;
    unique case (state_q)
      cci_pkg::StClear:  cmd_o.clr_wr = 1'b1;
      cci_pkg::StIdle: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = accept;
      end
      cci_pkg::StRead:   cmd_o.rd_en = 1'b1;
      cci_pkg::StDrain:  cmd_o = cmd_o;
      cci_pkg::StWrite:  cmd_o.wr_en = 1'b1;
      cci_pkg::StFinish: cmd_o.out_load = status_i.out_free;
      default:           cmd_o = cmd_o;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cci_pkg::StClear;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cci_datapath.sv
// Datapath of the class count integral image core: table memory, decode, accumulator.
`timescale 1ns / 1ps
`default_nettype none

module cci_datapath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  cci_pkg::ctl_cmd_t                   cmd_i,
  output cci_pkg::ctl_status_t                status_o,
  input  wire                                 cfg_we_i,
  input  wire  [cci_pkg::CoordW-1:0]          cfg_data_i,
  input  wire  [1:0]                          cmd_i_field,
  input  wire  [cci_pkg::ClassW-1:0]          cell_color_i,
  input  wire  [cci_pkg::CoordW-1:0]          row_start_i,
  input  wire  [cci_pkg::CoordW-1:0]          col_start_i,
  input  wire  [cci_pkg::CoordW-1:0]          row_end_i,
  input  wire  [cci_pkg::CoordW-1:0]          col_end_i,
  input  wire  [cci_pkg::CoordW-1:0]          side_len_i,
  input  wire  [3:0]                          region_i,
  input  wire  [cci_pkg::ClassW-1:0]          query_color_i,
  input  wire                                 out_stall_i,
  output logic                                out_valid_o,
  output logic [cci_pkg::CntW-1:0]            count_o,
  output logic                                bad_region_o
);

  cci_pkg::entry_t mem [cci_pkg::TableDepth];

  logic [cci_pkg::CoordW-1:0] grid_size_q;
  logic [cci_pkg::CoordW-1:0] n_eff;
  logic [cci_pkg::CoordW-1:0] load_row_q, load_col_q;
  logic [cci_pkg::AddrW-1:0]  clr_addr_q;

  cci_pkg::op_e  op;
  cci_pkg::rect_t rect_a_d, rect_b_d, rect_a_q, rect_b_q;
  logic use_b_d, use_b_q, in_bad, bad_q, is_load_q;
  logic [cci_pkg::ClassW-1:0] color_q;

  logic [cci_pkg::CoordW-1:0] h, sr_h, sc_h, br6, bc6, br_h, bc_h, lr, lc;
  logic [cci_pkg::CoordW:0]   br, bc;
  logic rect_bad, sq_bad;

  cci_pkg::entry_t acc_q, acc_d, rdata_q;
  logic rd_vld_q, rd_neg_q;

  cci_pkg::rect_t             rd_rect;
  logic [cci_pkg::CoordW-1:0] rd_row, rd_col;
  logic [cci_pkg::AddrW-1:0]  rd_addr, wr_addr;
  logic                       mem_we;
  cci_pkg::entry_t            wr_data;

  logic [cci_pkg::CoordW:0] next_col, next_row;

  logic out_valid_q, bad_out_q;
  logic [cci_pkg::CntW-1:0] count_q;
  logic out_free;

  // Effective grid side, clamped into the supported range.
  always_comb begin
    n_eff = grid_size_q;
    if (grid_size_q < cci_pkg::GridSizeMin) n_eff = cci_pkg::GridSizeMin;
    if (grid_size_q > cci_pkg::GridSizeMax) n_eff = cci_pkg::GridSizeMax;
  end

  // Decode of the incoming transaction.
  assign op   = cci_pkg::op_e'(cmd_i_field);
  assign h    = side_len_i >> 1;
  assign br   = {1'b0, row_start_i} + {1'b0, side_len_i};
  assign bc   = {1'b0, col_start_i} + {1'b0, side_len_i};
  assign br6  = br[cci_pkg::CoordW-1:0];
  assign bc6  = bc[cci_pkg::CoordW-1:0];
  assign sr_h = row_start_i + h;
  assign sc_h = col_start_i + h;
  assign br_h = br6 - h;
  assign bc_h = bc6 - h;

  assign rect_bad = (row_start_i > row_end_i) || (col_start_i > col_end_i) ||
                    (row_end_i > n_eff) || (col_end_i > n_eff);
  assign sq_bad   = (br > {1'b0, n_eff}) || (bc > {1'b0, n_eff});

  // A load whose position falls outside a shrunken grid restarts at the origin.
  always_comb begin
    lr = load_row_q;
    lc = load_col_q;
    if ((load_row_q >= n_eff) || (load_col_q >= n_eff)) begin
      lr = '0;
      lc = '0;
    end
  end

  always_comb begin
    rect_a_d = '{r0: row_start_i, c0: col_start_i, r1: br6, c1: bc6};
    rect_b_d = rect_a_d;
    use_b_d  = 1'b0;
    in_bad   = 1'b0;
    case (op)
      cci_pkg::OpLoad: begin
        rect_a_d = '{r0: lr, c0: lc, r1: lr + 1'b1, c1: lc + 1'b1};
      end
      cci_pkg::OpRect: begin
        in_bad   = rect_bad;
        rect_a_d = '{r0: row_start_i, c0: col_start_i, r1: row_end_i, c1: col_end_i};
      end
      cci_pkg::OpRegion: begin
        in_bad = sq_bad;
        case (region_i)
          cci_pkg::RegTop:    rect_a_d = '{r0: row_start_i, c0: col_start_i, r1: sr_h, c1: bc6};
          cci_pkg::RegBottom: rect_a_d = '{r0: br_h, c0: col_start_i, r1: br6, c1: bc6};
          cci_pkg::RegLeft:   rect_a_d = '{r0: row_start_i, c0: col_start_i, r1: br6, c1: sc_h};
          cci_pkg::RegRight:  rect_a_d = '{r0: row_start_i, c0: bc_h, r1: br6, c1: bc6};
          cci_pkg::RegMinusBr: begin
            use_b_d  = 1'b1;
            rect_b_d = '{r0: br_h, c0: bc_h, r1: br6, c1: bc6};
          end
          cci_pkg::RegMinusBl: begin
            use_b_d  = 1'b1;
            rect_b_d = '{r0: br_h, c0: col_start_i, r1: br6, c1: sc_h};
          end
          cci_pkg::RegMinusTr: begin
            use_b_d  = 1'b1;
            rect_b_d = '{r0: row_start_i, c0: bc_h, r1: sr_h, c1: bc6};
          end
          cci_pkg::RegMinusTl: begin
            use_b_d  = 1'b1;
            rect_b_d = '{r0: row_start_i, c0: col_start_i, r1: sr_h, c1: sc_h};
          end
          default: use_b_d = 1'b0;
        endcase
      end
      default: in_bad = 1'b0;
    endcase
  end

  // Corner of the current step: step bit 2 picks the rectangle, bits 1:0 the corner
  // in the order (r1,c1) (r0,c0) (r1,c0) (r0,c1); in a query, A: + + - -, B: - - + +.
  assign rd_rect = cmd_i.step[2] ? rect_b_q : rect_a_q;
  assign rd_row  = cmd_i.step[0] ? rd_rect.r0 : rd_rect.r1;
  assign rd_col  = (cmd_i.step[0] ^ cmd_i.step[1]) ? rd_rect.c0 : rd_rect.c1;
  assign rd_addr = cci_pkg::table_addr(rd_row, rd_col);

  assign mem_we  = cmd_i.clr_wr || cmd_i.wr_en;
  assign wr_addr = cmd_i.clr_wr ? clr_addr_q : cci_pkg::table_addr(rect_a_q.r1, rect_a_q.c1);
  assign wr_data = cmd_i.clr_wr ? '0 : acc_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rdata_q <= mem[rd_addr];
  end

  // Accumulator: seeded at accept, then one corner per cycle behind the memory read.
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.accept) begin
      for (int i = 0; i < cci_pkg::NumClass; i++) begin
        acc_d[i] = ((op == cci_pkg::OpLoad) && (cell_color_i == cci_pkg::ClassW'(i)))
                   ? cci_pkg::CntW'(1) : '0;
      end
    end else if (rd_vld_q) begin
      for (int i = 0; i < cci_pkg::NumClass; i++) begin
        acc_d[i] = rd_neg_q ? acc_q[i] - rdata_q[i] : acc_q[i] + rdata_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.accept) begin
      rect_a_q <= rect_a_d;
      rect_b_q <= rect_b_d;
      color_q  <= query_color_i;
    end
  end

  // A load runs the corners with the opposite signs of a rectangle sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_neg_q  <= 1'b0;
      use_b_q   <= 1'b0;
      bad_q     <= 1'b0;
      is_load_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_neg_q <= cmd_i.step[1] ^ cmd_i.step[2] ^ is_load_q;
      if (cmd_i.accept) begin
        use_b_q   <= use_b_d;
        bad_q     <= in_bad;
        is_load_q <= (op == cci_pkg::OpLoad);
      end
    end
  end

  // Configuration register, clear sweep and load position.
  assign next_col = {1'b0, rect_a_q.c0} + 1'b1;
  assign next_row = {1'b0, rect_a_q.r0} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= cci_pkg::GridSizeReset;
      clr_addr_q  <= '0;
      load_row_q  <= '0;
      load_col_q  <= '0;
    end else begin
      if (cfg_we_i) grid_size_q <= cfg_data_i;
      if (cmd_i.clr_wr) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.wr_en) begin
        if (next_col >= {1'b0, n_eff}) begin
          load_col_q <= '0;
          load_row_q <= (next_row >= {1'b0, n_eff}) ? '0 : next_row[cci_pkg::CoordW-1:0];
        end else begin
          load_col_q <= next_col[cci_pkg::CoordW-1:0];
          load_row_q <= rect_a_q.r0;
        end
      end
    end
  end

  // Output register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      count_q   <= acc_q[color_q];
      bad_out_q <= bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign count_o      = count_q;
  assign bad_region_o = bad_out_q;

  assign status_o.in_op      = op;
  assign status_o.in_bad     = in_bad;
  assign status_o.use_b      = use_b_q;
  assign status_o.is_load    = is_load_q;
  assign status_o.clear_last = (clr_addr_q == cci_pkg::AddrW'(cci_pkg::TableDepth - 1));
  assign status_o.out_free   = out_free;

endmodule

`default_nettype wire

>>> hw/rtl/class_count_integral_image_core.sv
// Top level of the class count integral image core.
//
// The core keeps a per-class summed-area table of a square grid with four
// classes. Input transactions (in_valid_i / in_stall_o) carry a command: a
// load writes the next cell in raster order, a rectangle query or a square
// region query returns the count of one class. Loads return nothing; each
// query returns one transaction on the output channel (out_valid_o /
// out_stall_i) with count_o and bad_region_o. The grid side is written on
// the configuration channel (cfg_valid_i / cfg_ready_o); the user is to write
// it only while the core idles, which the core does not enforce. The table
// sits in one single-port memory, one access per cycle, and that port sets
// the pace: an item passes the accept, its corner reads, a drain step and a
// closing step (the table write of a load or the output load of a query). A
// load reads three corners, a rectangle or half query four, a square minus a
// quadrant eight; a bad region skips the reads and drain, an unused command
// stops at the accept. After reset the core sweeps the whole table to zero,
// one entry a cycle, with in_stall_o high; configuration writes are taken.
// A finished result waits in the output register while the receiver
// stalls, and the core keeps working on the next transaction; only a
// second result that is ready while the first is still held waits.
`timescale 1ns / 1ps
`default_nettype none

module class_count_integral_image_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Configuration channel.
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [cci_pkg::CoordW-1:0]   cfg_data_i,
  // Input channel.
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [1:0]                   cmd_i,
  input  wire  [cci_pkg::ClassW-1:0]   cell_color_i,
  input  wire  [cci_pkg::CoordW-1:0]   row_start_i,
  input  wire  [cci_pkg::CoordW-1:0]   col_start_i,
  input  wire  [cci_pkg::CoordW-1:0]   row_end_i,
  input  wire  [cci_pkg::CoordW-1:0]   col_end_i,
  input  wire  [cci_pkg::CoordW-1:0]   side_len_i,
  input  wire  [3:0]                   region_i,
  input  wire  [cci_pkg::ClassW-1:0]   query_color_i,
  // Output channel.
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [cci_pkg::CntW-1:0]     count_o,
  output logic                         bad_region_o
);

  cci_pkg::ctl_cmd_t    ctl_cmd;
  cci_pkg::ctl_status_t ctl_status;
  logic                 cfg_we;

  // The register may be written at any time; the core only reads it in a
  // transaction. The user must write it only while idle; nothing checks it.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  cci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (ctl_status),
    .cmd_o      (ctl_cmd)
  );

  cci_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctl_cmd),
    .status_o      (ctl_status),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .cmd_i_field   (cmd_i),
    .cell_color_i  (cell_color_i),
    .row_start_i   (row_start_i),
    .col_start_i   (col_start_i),
    .row_end_i     (row_end_i),
    .col_end_i     (col_end_i),
    .side_len_i    (side_len_i),
    .region_i      (region_i),
    .query_color_i (query_color_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .count_o       (count_o),
    .bad_region_o  (bad_region_o)
  );

endmodule

`default_nettype wire
